// File: hw/rtl/jttb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the JSON token table builder.
// Used by the controller, the datapath and the top level; depends on nothing.
package jttb_pkg;

    localparam int MAX_TOKENS_D  = 1024;
    localparam int OFFSET_BITS_D = 20;

    // Byte codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_S  = 8'h73;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Result kinds.
    localparam logic [1:0] RK_FINISHED = 2'd0;
    localparam logic [1:0] RK_CHILD    = 2'd1;
    localparam logic [1:0] RK_ERROR    = 2'd2;
    localparam logic [1:0] RK_END      = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MISMATCH  = 3'd1;
    localparam logic [2:0] ST_BAD_BYTE  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_LIT   = 3'd4;
    localparam logic [2:0] ST_NO_OPEN   = 3'd5;

    typedef enum logic [2:0] {
        TK_OBJECT = 3'd0,
        TK_ARRAY  = 3'd1,
        TK_STRING = 3'd2,
        TK_NUMBER = 3'd3,
        TK_BOOL   = 3'd4
    } t_tkind;

    typedef enum logic [2:0] {
        M_IDLE, M_STRING, M_NUMBER, M_LITERAL, M_DISCARD
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_HDL,
        S_NEW, S_NEW_WR, S_NEW_CHK, S_PAR_RD, S_PAR_LD, S_PAR_INC, S_PAR_WR, S_NEW_POST,
        S_EMIT_RD, S_EMIT_LD, S_EMIT,
        S_FIN_RD, S_FIN_LD, S_FIN_LEN, S_FIN_WR,
        S_WALK, S_WALK_LD, S_WALK_EV, S_CLOSE_WR,
        S_CM_RD, S_CM_LD, S_CM_EV,
        S_FAIL, S_END, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        TS_NONE, TS_USED_M1, TS_ACTIVE, TS_PARENT, TS_USED, TS_NEWT
    } t_tsel;

    typedef enum logic [1:0] {
        AS_NONE, AS_NEWT, AS_PARENT, AS_USED_M1
    } t_asel;

    typedef enum logic [1:0] {
        SS_POS, SS_POS1, SS_LIT
    } t_ssel;

    typedef enum logic [1:0] {
        LS_OPEN, LS_ZERO, LS_LIT
    } t_lsel;

    typedef enum logic [2:0] {
        PU_NONE, PU_FIN, PU_CHILD, PU_ERR, PU_END
    } t_push;

    typedef struct packed {
        logic       accept;
        t_tsel      tsel;
        logic       rd;
        logic       ent_load;
        logic       ent_new;
        t_tkind     nkind;
        t_ssel      ssel;
        t_lsel      lsel;
        logic       ent_inc;
        logic       ent_len;
        logic       len_plus1;
        logic       wr;
        logic       used_inc;
        logic       newt_save;
        t_asel      asel;
        t_push      push;
        logic [2:0] code;
        logic       flush;
        logic       clear;
        logic       lit_start;
        logic       lit_step;
    } t_cmd;

    typedef struct packed {
        logic ws;
        logic nul;
        logic open_obj;
        logic open_arr;
        logic close_obj;
        logic close_arr;
        logic quote;
        logic num_start;
        logic digit_dot;
        logic lit_t;
        logic lit_f;
        logic colon;
        logic comma;
        logic lit_ok;
        logic lit_done;
        logic full;
        logic act_ok;
        logic tidx_bad;
        logic ent_open_cont;
        logic ent_is_cont;
        logic ent_is_obj;
        logic push_ok;
        logic stg_v;
        logic out_free;
    } t_sts;

    function automatic logic [7:0] lit_char(input logic is_true, input logic [2:0] step);
        logic [7:0] c;
        c = CH_NUL;
        if (is_true) begin
            case (step)
                3'd0: c = CH_LOW_T;
                3'd1: c = CH_LOW_R;
                3'd2: c = CH_LOW_U;
                3'd3: c = CH_LOW_E;
                default: c = CH_NUL;
            endcase
        end else begin
            case (step)
                3'd0: c = CH_LOW_F;
                3'd1: c = CH_LOW_A;
                3'd2: c = CH_LOW_L;
                3'd3: c = CH_LOW_S;
                3'd4: c = CH_LOW_E;
                default: c = CH_NUL;
            endcase
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/jttb_ctrl.sv
`timescale 1ns / 1ps
// Controller of the JSON token table builder: lexer mode and the sequencer
// that steps the datapath through table reads, writes and result pushes. Uses jttb_pkg.
module jttb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_doc_valid,
    output logic            o_doc_ready,
    input  jttb_pkg::t_sts  i_sts,
    output jttb_pkg::t_cmd  o_cmd
);
    import jttb_pkg::*;

    t_state     r_state, n_state;
    t_mode      r_mode, n_mode;
    t_tkind     r_nkind, n_nkind;
    logic [2:0] r_code, n_code;
    logic       r_end, n_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_IDLE;
            r_nkind <= TK_OBJECT;
            r_code  <= ST_OK;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_nkind <= n_nkind;
            r_code  <= n_code;
            r_end   <= n_end;
        end
    end

    // Next state and lexer state.
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_nkind = r_nkind;
        n_code  = r_code;
        n_end   = r_end;
        case (r_state)
            S_IDLE: if (i_doc_valid) n_state = S_DECODE;
            S_DECODE: begin
                case (r_mode)
                    M_STRING: begin
                        if (i_sts.quote) n_state = S_FIN_RD;
                        else if (i_sts.nul) begin
                            n_code = ST_BAD_BYTE; n_end = 1'b1; n_state = S_FAIL;
                        end else n_state = S_DONE;
                    end
                    M_NUMBER: n_state = i_sts.digit_dot ? S_DONE : S_FIN_RD;
                    M_LITERAL: begin
                        if (!i_sts.lit_ok) begin
                            n_code = ST_BAD_LIT; n_end = i_sts.nul; n_state = S_FAIL;
                        end else if (i_sts.lit_done) begin
                            n_mode = M_IDLE; n_nkind = TK_BOOL; n_state = S_NEW;
                        end else n_state = S_DONE;
                    end
                    M_DISCARD: n_state = i_sts.nul ? S_END : S_DONE;
                    default: n_state = S_HDL;
                endcase
            end
            S_HDL: begin
                if (i_sts.ws) n_state = S_DONE;
                else if (i_sts.nul) n_state = S_END;
                else if (i_sts.open_obj) begin
                    n_nkind = TK_OBJECT; n_state = S_NEW;
                end else if (i_sts.open_arr) begin
                    n_nkind = TK_ARRAY; n_state = S_NEW;
                end else if (i_sts.close_obj || i_sts.close_arr) n_state = S_WALK;
                else if (i_sts.quote) begin
                    n_nkind = TK_STRING; n_state = S_NEW;
                end else if (i_sts.num_start) begin
                    n_nkind = TK_NUMBER; n_state = S_NEW;
                end else if (i_sts.lit_t || i_sts.lit_f) begin
                    n_mode = M_LITERAL; n_state = S_DONE;
                end else if (i_sts.colon) n_state = S_DONE;
                else if (i_sts.comma) n_state = i_sts.act_ok ? S_CM_RD : S_DONE;
                else begin
                    n_code = ST_BAD_BYTE; n_end = 1'b0; n_state = S_FAIL;
                end
            end
            S_NEW: begin
                if (i_sts.full) begin
                    n_code = ST_FULL; n_end = 1'b0; n_state = S_FAIL;
                end else n_state = S_NEW_WR;
            end
            S_NEW_WR:  n_state = S_NEW_CHK;
            S_NEW_CHK: n_state = i_sts.act_ok ? S_PAR_RD : S_NEW_POST;
            S_PAR_RD:  n_state = S_PAR_LD;
            S_PAR_LD:  n_state = S_PAR_INC;
            S_PAR_INC: n_state = S_PAR_WR;
            S_PAR_WR:  if (i_sts.push_ok) n_state = S_NEW_POST;
            S_NEW_POST: begin
                case (r_nkind)
                    TK_STRING: begin n_mode = M_STRING; n_state = S_DONE; end
                    TK_NUMBER: begin n_mode = M_NUMBER; n_state = S_DONE; end
                    TK_BOOL:   n_state = S_EMIT_RD;
                    default:   n_state = S_DONE;
                endcase
            end
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: n_state = S_EMIT;
            S_EMIT:    if (i_sts.push_ok) n_state = S_DONE;
            S_FIN_RD:  n_state = S_FIN_LD;
            S_FIN_LD:  n_state = S_FIN_LEN;
            S_FIN_LEN: n_state = S_FIN_WR;
            S_FIN_WR: begin
                if (i_sts.push_ok) begin
                    // A number ends on a byte that still has to be lexed.
                    n_state = (r_mode == M_NUMBER) ? S_HDL : S_DONE;
                    n_mode  = M_IDLE;
                end
            end
            S_WALK: begin
                if (i_sts.tidx_bad) begin
                    n_code = ST_NO_OPEN; n_end = 1'b0; n_state = S_FAIL;
                end else n_state = S_WALK_LD;
            end
            S_WALK_LD: n_state = S_WALK_EV;
            S_WALK_EV: begin
                if (i_sts.ent_open_cont) begin
                    if (i_sts.close_obj != i_sts.ent_is_obj) begin
                        n_code = ST_MISMATCH; n_end = 1'b0; n_state = S_FAIL;
                    end else n_state = S_CLOSE_WR;
                end else n_state = S_WALK;
            end
            S_CLOSE_WR: if (i_sts.push_ok) n_state = S_DONE;
            S_CM_RD:   n_state = S_CM_LD;
            S_CM_LD:   n_state = S_CM_EV;
            S_CM_EV:   n_state = S_DONE;
            S_FAIL: begin
                if (i_sts.push_ok) begin
                    n_mode  = M_DISCARD;
                    n_state = r_end ? S_END : S_DONE;
                end
            end
            S_END: begin
                if (i_sts.push_ok) begin
                    n_mode = M_IDLE; n_state = S_DONE;
                end
            end
            S_DONE: if (!i_sts.stg_v || i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        o_doc_ready = 1'b0;
        case (r_nkind)
            TK_OBJECT, TK_ARRAY: begin o_cmd.ssel = SS_POS;  o_cmd.lsel = LS_OPEN; end
            TK_STRING:           begin o_cmd.ssel = SS_POS1; o_cmd.lsel = LS_ZERO; end
            TK_NUMBER:           begin o_cmd.ssel = SS_POS;  o_cmd.lsel = LS_ZERO; end
            default:             begin o_cmd.ssel = SS_LIT;  o_cmd.lsel = LS_LIT;  end
        endcase
        o_cmd.nkind = r_nkind;
        o_cmd.code  = r_code;
        case (r_state)
            S_IDLE: begin
                o_doc_ready  = 1'b1;
                o_cmd.accept = i_doc_valid;
            end
            S_DECODE: begin
                if (r_mode == M_STRING && i_sts.quote) o_cmd.tsel = TS_USED_M1;
                if (r_mode == M_NUMBER && !i_sts.digit_dot) o_cmd.tsel = TS_USED_M1;
                if (r_mode == M_LITERAL && i_sts.lit_ok) o_cmd.lit_step = 1'b1;
            end
            S_HDL: begin
                if (!i_sts.ws && !i_sts.nul) begin
                    if (i_sts.close_obj || i_sts.close_arr) o_cmd.tsel = TS_ACTIVE;
                    else if (i_sts.lit_t || i_sts.lit_f) o_cmd.lit_start = 1'b1;
                    else if (i_sts.colon) o_cmd.asel = AS_USED_M1;
                    else if (i_sts.comma && i_sts.act_ok) o_cmd.tsel = TS_ACTIVE;
                end
            end
            S_NEW: begin
                if (!i_sts.full) begin
                    o_cmd.ent_new = 1'b1;
                    o_cmd.tsel    = TS_USED;
                end
            end
            S_NEW_WR: begin
                o_cmd.wr        = 1'b1;
                o_cmd.used_inc  = 1'b1;
                o_cmd.newt_save = 1'b1;
            end
            S_NEW_CHK: if (i_sts.act_ok) o_cmd.tsel = TS_ACTIVE;
            S_PAR_RD, S_EMIT_RD, S_FIN_RD, S_CM_RD: o_cmd.rd = 1'b1;
            S_PAR_LD, S_EMIT_LD, S_FIN_LD, S_WALK_LD, S_CM_LD: o_cmd.ent_load = 1'b1;
            S_PAR_INC: o_cmd.ent_inc = 1'b1;
            S_PAR_WR: begin
                if (i_sts.push_ok) begin
                    o_cmd.wr   = 1'b1;
                    o_cmd.push = PU_CHILD;
                end
            end
            S_NEW_POST: begin
                if (r_nkind == TK_OBJECT || r_nkind == TK_ARRAY) o_cmd.asel = AS_NEWT;
                if (r_nkind == TK_BOOL) o_cmd.tsel = TS_NEWT;
            end
            S_EMIT: if (i_sts.push_ok) o_cmd.push = PU_FIN;
            S_FIN_LEN: o_cmd.ent_len = 1'b1;
            S_FIN_WR: begin
                if (i_sts.push_ok) begin
                    o_cmd.wr   = 1'b1;
                    o_cmd.push = PU_FIN;
                end
            end
            S_WALK: if (!i_sts.tidx_bad) o_cmd.rd = 1'b1;
            S_WALK_EV: begin
                if (i_sts.ent_open_cont) begin
                    if (i_sts.close_obj == i_sts.ent_is_obj) begin
                        o_cmd.ent_len   = 1'b1;
                        o_cmd.len_plus1 = 1'b1;
                    end
                end else o_cmd.tsel = TS_PARENT;
            end
            S_CLOSE_WR: begin
                if (i_sts.push_ok) begin
                    o_cmd.wr   = 1'b1;
                    o_cmd.asel = AS_PARENT;
                    o_cmd.push = PU_FIN;
                end
            end
            S_CM_EV: if (!i_sts.ent_is_cont) o_cmd.asel = AS_PARENT;
            S_FAIL: if (i_sts.push_ok) o_cmd.push = PU_ERR;
            S_END: begin
                if (i_sts.push_ok) begin
                    o_cmd.push  = PU_END;
                    o_cmd.clear = 1'b1;
                end
            end
            S_DONE: if (i_sts.stg_v && i_sts.out_free) o_cmd.flush = 1'b1;
            default: o_cmd.accept = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/jttb_dp.sv
`timescale 1ns / 1ps
// Datapath of the JSON token table builder: token table memory, lexer
// counters, entry working register and the two-deep result buffer. Uses jttb_pkg.
module jttb_dp #(
    parameter int MAX_TOKENS  = jttb_pkg::MAX_TOKENS_D,
    parameter int OFFSET_BITS = jttb_pkg::OFFSET_BITS_D,
    localparam int AW = $clog2(MAX_TOKENS),
    localparam int IW = AW + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  jttb_pkg::t_cmd         i_cmd,
    output jttb_pkg::t_sts         o_sts,
    input  logic [7:0]             i_doc_byte,
    input  logic                   i_res_ready,
    output logic                   o_res_valid,
    output logic [1:0]             o_kind,
    output logic [IW-1:0]          o_token_index,
    output logic [2:0]             o_token_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [OFFSET_BITS-1:0] o_text_length,
    output logic signed [IW-1:0]   o_parent_index,
    output logic [IW-1:0]          o_child_count,
    output logic [2:0]             o_status,
    output logic                   o_last
);
    import jttb_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int EW = 3 + OB + (OB + 1) + IW + IW;
    localparam logic [IW-1:0] MAX_CNT = IW'(MAX_TOKENS);

    // Lexer and table bookkeeping.
    logic [7:0]    r_byte;
    logic [OB-1:0] r_pos, r_p;
    logic [IW-1:0] r_used, r_active, r_tidx, r_newt;
    logic [2:0]    r_err;
    logic [2:0]    r_lit_step;
    logic          r_lit_true;

    // Entry working register; the top bit of the length marks an open container.
    logic [2:0]    r_ek;
    logic [OB-1:0] r_es;
    logic [OB:0]   r_el;
    logic [IW-1:0] r_ep, r_ec;

    logic [EW-1:0] mem [MAX_TOKENS];
    logic [EW-1:0] r_rdata;

    // Staged result and output register.
    logic          r_stg_v, r_out_v, r_out_last;
    logic [1:0]    r_sk, r_ok;
    logic [IW-1:0] r_si, r_oi, r_sp, r_op, r_sc, r_oc;
    logic [2:0]    r_stk, r_otk, r_sst, r_ost;
    logic [OB-1:0] r_ss, r_os, r_sl, r_ol;

    logic [OB-1:0] len_calc, start_calc;
    logic [OB:0]   len_new;
    logic [2:0]    lit_n;
    logic          push_ok, out_free;
    logic [1:0]    nr_k;
    logic [IW-1:0] nr_i, nr_p, nr_c;
    logic [2:0]    nr_tk, nr_st;
    logic [OB-1:0] nr_s, nr_l;

    assign lit_n    = r_lit_true ? 3'd4 : 3'd5;
    assign len_calc = r_p + OB'(i_cmd.len_plus1) - r_es;
    assign out_free = !r_out_v || i_res_ready;
    assign push_ok  = !r_stg_v || out_free;

    always_comb begin
        case (i_cmd.ssel)
            SS_POS:  start_calc = r_p;
            SS_POS1: start_calc = r_p + OB'(1);
            default: start_calc = r_p - (r_lit_true ? OB'(3) : OB'(4));
        endcase
        case (i_cmd.lsel)
            LS_OPEN: len_new = {1'b1, {OB{1'b0}}};
            LS_ZERO: len_new = '0;
            default: len_new = {1'b0, OB'(lit_n)};
        endcase
    end

    always_comb begin
        o_sts.ws        = (r_byte == CH_SPACE) || (r_byte == CH_TAB) ||
                          (r_byte == CH_CR) || (r_byte == CH_LF);
        o_sts.nul       = (r_byte == CH_NUL);
        o_sts.open_obj  = (r_byte == CH_LBRACE);
        o_sts.open_arr  = (r_byte == CH_LBRACK);
        o_sts.close_obj = (r_byte == CH_RBRACE);
        o_sts.close_arr = (r_byte == CH_RBRACK);
        o_sts.quote     = (r_byte == CH_QUOTE);
        o_sts.num_start = ((r_byte >= CH_ZERO) && (r_byte <= CH_NINE)) || (r_byte == CH_MINUS);
        o_sts.digit_dot = ((r_byte >= CH_ZERO) && (r_byte <= CH_NINE)) || (r_byte == CH_DOT);
        o_sts.lit_t     = (r_byte == CH_LOW_T);
        o_sts.lit_f     = (r_byte == CH_LOW_F);
        o_sts.colon     = (r_byte == CH_COLON);
        o_sts.comma     = (r_byte == CH_COMMA);
        o_sts.lit_ok    = (r_lit_step < lit_n) && (r_byte == lit_char(r_lit_true, r_lit_step));
        o_sts.lit_done  = ((r_lit_step + 3'd1) == lit_n);
        o_sts.full      = (r_used >= MAX_CNT);
        o_sts.act_ok    = !r_active[IW-1] && (r_active < r_used);
        o_sts.tidx_bad  = r_tidx[IW-1] || (r_tidx >= r_used);
        o_sts.ent_is_cont   = (r_ek == TK_OBJECT) || (r_ek == TK_ARRAY);
        o_sts.ent_open_cont = o_sts.ent_is_cont && r_el[OB];
        o_sts.ent_is_obj    = (r_ek == TK_OBJECT);
        o_sts.push_ok   = push_ok;
        o_sts.stg_v     = r_stg_v;
        o_sts.out_free  = out_free;
    end

    // Result built for the current push.
    always_comb begin
        nr_k  = RK_FINISHED;
        nr_i  = r_tidx;
        nr_tk = r_ek;
        nr_s  = r_es;
        nr_l  = r_el[OB] ? '0 : r_el[OB-1:0];
        nr_p  = r_ep;
        nr_c  = r_ec;
        nr_st = ST_OK;
        case (i_cmd.push)
            PU_CHILD: nr_k = RK_CHILD;
            PU_ERR: begin
                nr_k = RK_ERROR; nr_i = '0; nr_tk = '0; nr_s = '0; nr_l = '0;
                nr_p = '0; nr_c = '0; nr_st = i_cmd.code;
            end
            PU_END: begin
                nr_k = RK_END; nr_i = r_used; nr_tk = '0; nr_s = '0; nr_l = '0;
                nr_p = '0; nr_c = '0; nr_st = r_err;
            end
            default: nr_k = RK_FINISHED;
        endcase
    end

    // Token table: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) mem[r_tidx[AW-1:0]] <= {r_ek, r_es, r_el, r_ep, r_ec};
        if (i_cmd.rd) r_rdata <= mem[r_tidx[AW-1:0]];
    end

    // Control state of the lexer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_used     <= '0;
            r_active   <= '1;
            r_err      <= ST_OK;
            r_lit_step <= '0;
            r_lit_true <= 1'b0;
            r_stg_v    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (i_cmd.accept) r_pos <= r_pos + OB'(1);
            if (i_cmd.used_inc) r_used <= r_used + IW'(1);
            case (i_cmd.asel)
                AS_NEWT:    r_active <= r_newt;
                AS_PARENT:  r_active <= r_ep;
                AS_USED_M1: r_active <= r_used - IW'(1);
                default:    r_active <= r_active;
            endcase
            if (i_cmd.push == PU_ERR) r_err <= i_cmd.code;
            if (i_cmd.lit_start) begin
                r_lit_step <= 3'd1;
                r_lit_true <= (r_byte == CH_LOW_T);
            end else if (i_cmd.lit_step) begin
                r_lit_step <= r_lit_step + 3'd1;
            end
            if (r_out_v && i_res_ready) r_out_v <= 1'b0;
            if ((i_cmd.push != PU_NONE && r_stg_v) || i_cmd.flush) r_out_v <= 1'b1;
            if (i_cmd.push != PU_NONE) r_stg_v <= 1'b1;
            else if (i_cmd.flush) r_stg_v <= 1'b0;
            if (i_cmd.clear) begin
                r_pos      <= '0;
                r_used     <= '0;
                r_active   <= '1;
                r_err      <= ST_OK;
                r_lit_step <= '0;
                r_lit_true <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_doc_byte;
            r_p    <= r_pos;
        end
        case (i_cmd.tsel)
            TS_USED_M1: r_tidx <= r_used - IW'(1);
            TS_ACTIVE:  r_tidx <= r_active;
            TS_PARENT:  r_tidx <= r_ep;
            TS_USED:    r_tidx <= r_used;
            TS_NEWT:    r_tidx <= r_newt;
            default:    r_tidx <= r_tidx;
        endcase
        if (i_cmd.newt_save) r_newt <= r_tidx;
        if (i_cmd.ent_load) begin
            {r_ek, r_es, r_el, r_ep, r_ec} <= r_rdata;
        end else if (i_cmd.ent_new) begin
            r_ek <= i_cmd.nkind;
            r_es <= start_calc;
            r_el <= len_new;
            r_ep <= r_active;
            r_ec <= '0;
        end else if (i_cmd.ent_inc) begin
            r_ec <= r_ec + IW'(1);
        end else if (i_cmd.ent_len) begin
            r_el <= {1'b0, len_calc};
        end
        // The older staged word moves out ahead of the new one.
        if ((i_cmd.push != PU_NONE && r_stg_v) || i_cmd.flush) begin
            r_ok       <= r_sk;
            r_oi       <= r_si;
            r_otk      <= r_stk;
            r_os       <= r_ss;
            r_ol       <= r_sl;
            r_op       <= r_sp;
            r_oc       <= r_sc;
            r_ost      <= r_sst;
            r_out_last <= i_cmd.flush;
        end
        if (i_cmd.push != PU_NONE) begin
            r_sk  <= nr_k;
            r_si  <= nr_i;
            r_stk <= nr_tk;
            r_ss  <= nr_s;
            r_sl  <= nr_l;
            r_sp  <= nr_p;
            r_sc  <= nr_c;
            r_sst <= nr_st;
        end
    end

    assign o_res_valid    = r_out_v;
    assign o_kind         = r_ok;
    assign o_token_index  = r_oi;
    assign o_token_kind   = r_otk;
    assign o_start_offset = r_os;
    assign o_text_length  = r_ol;
    assign o_parent_index = $signed(r_op);
    assign o_child_count  = r_oc;
    assign o_status       = r_ost;
    assign o_last         = r_out_last;

endmodule

// File: hw/rtl/json_token_table_builder.sv
`timescale 1ns / 1ps
// Top level of the JSON token table builder: controller plus datapath.
// Depends on jttb_pkg, jttb_ctrl and jttb_dp.
//
// Input channel: one document byte per word on i_doc_byte with i_doc_valid /
// o_doc_ready. A NUL byte ends the document and returns the block to its
// initial state. Output channel: result words with o_res_valid / i_res_ready;
// each byte causes zero, one or two words, and o_last marks the final one.
// Creating a token writes its table entry; under a parent it also reads
// the parent entry, increments its child count and writes it back. A close
// byte reads the entries on the parent chain up to the innermost open container.
// Results pass through a staging word and an output register, so a byte is
// taken while the last word still waits; when the receiver stalls the block
// holds its next result and stops taking bytes. After reset the table is
// empty, no token is active, and the byte offset is zero.
module json_token_table_builder #(
    parameter int MAX_TOKENS  = jttb_pkg::MAX_TOKENS_D,
    parameter int OFFSET_BITS = jttb_pkg::OFFSET_BITS_D,
    localparam int IW = $clog2(MAX_TOKENS) + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_doc_valid,
    output logic                   o_doc_ready,
    input  logic [7:0]             i_doc_byte,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output logic [1:0]             o_kind,
    output logic [IW-1:0]          o_token_index,
    output logic [2:0]             o_token_kind,
    output logic [OFFSET_BITS-1:0] o_start_offset,
    output logic [OFFSET_BITS-1:0] o_text_length,
    output logic signed [IW-1:0]   o_parent_index,
    output logic [IW-1:0]          o_child_count,
    output logic [2:0]             o_status,
    output logic                   o_last
);
    import jttb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    jttb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_doc_valid (i_doc_valid),
        .o_doc_ready (o_doc_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    jttb_dp #(
        .MAX_TOKENS  (MAX_TOKENS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_doc_byte     (i_doc_byte),
        .i_res_ready    (i_res_ready),
        .o_res_valid    (o_res_valid),
        .o_kind         (o_kind),
        .o_token_index  (o_token_index),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_text_length  (o_text_length),
        .o_parent_index (o_parent_index),
        .o_child_count  (o_child_count),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

// File: tb/json_token_table_checker.sv
`timescale 1ns / 1ps
// Result checker for the JSON token table builder: watches both channels,
// predicts the result words of every accepted byte and compares them.
// Depends on jttb_pkg for the result kinds, status codes and token kinds.
module json_token_table_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_doc_valid,
    input  logic              i_doc_ready,
    input  logic [7:0]        i_doc_byte,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [1:0]        i_kind,
    input  logic [10:0]       i_token_index,
    input  logic [2:0]        i_token_kind,
    input  logic [19:0]       i_start_offset,
    input  logic [19:0]       i_text_length,
    input  logic signed [10:0] i_parent_index,
    input  logic [10:0]       i_child_count,
    input  logic [2:0]        i_status,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending
);
    import jttb_pkg::*;

    localparam int NTOK = 1024;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] idx;
        logic [2:0]  tkind;
        logic [19:0] start;
        logic [19:0] len;
        logic [10:0] parent;
        logic [10:0] kids;
        logic [2:0]  status;
        logic        last;
    } t_word;

    t_word       expected_words[$];
    t_word       byte_words[$];

    // Token table copy; bit 20 of a length marks a container still open.
    logic [2:0]  tok_kind  [NTOK];
    logic [19:0] tok_start [NTOK];
    logic [20:0] tok_len   [NTOK];
    logic [10:0] tok_par   [NTOK];
    logic [10:0] tok_kids  [NTOK];
    int          active;
    int          used;
    logic [19:0] pos;
    t_mode       mode;
    int          lit_pos;
    bit          lit_true;
    logic [2:0]  err_code;
    int          mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_words.size();

    task automatic clear_state();
        active   = -1;
        used     = 0;
        pos      = '0;
        mode     = M_IDLE;
        lit_pos  = 0;
        lit_true = 0;
        err_code = ST_OK;
    endtask

    task automatic add_word(logic [1:0] k, int idx, logic [2:0] tk, logic [19:0] st,
                            logic [19:0] ln, logic [10:0] par, logic [10:0] kids,
                            logic [2:0] code);
        t_word w;
        if (byte_words.size() < 2) begin
            w = '{k, idx[10:0], tk, st, ln, par, kids, code, 1'b0};
            byte_words.push_back(w);
        end
    endtask

    task automatic add_entry(logic [1:0] k, int t);
        logic [19:0] ln;
        ln = tok_len[t][20] ? 20'd0 : tok_len[t][19:0];
        add_word(k, t, tok_kind[t], tok_start[t], ln, tok_par[t], tok_kids[t], ST_OK);
    endtask

    task automatic raise_error(logic [2:0] code);
        err_code = code;
        mode     = M_DISCARD;
        add_word(RK_ERROR, 0, 0, 0, 0, 0, 0, code);
    endtask

    task automatic finish_doc();
        add_word(RK_END, used, 0, 0, 0, 0, 0, err_code);
        clear_state();
    endtask

    task automatic open_token(logic [2:0] k, logic [19:0] st, logic [20:0] ln,
                              output int t);
        if (used >= NTOK) begin
            raise_error(ST_FULL);
            t = -1;
        end else begin
            t = used;
            used++;
            tok_kind[t]  = k;
            tok_start[t] = st;
            tok_len[t]   = ln;
            tok_par[t]   = active[10:0];
            tok_kids[t]  = '0;
            if (active >= 0 && active < used) begin
                tok_kids[active] = tok_kids[active] + 1'b1;
                add_entry(RK_CHILD, active);
            end
        end
    endtask

    function automatic bit is_cont(int t);
        return tok_kind[t] == TK_OBJECT || tok_kind[t] == TK_ARRAY;
    endfunction

    task automatic close_cont(logic [2:0] want, logic [19:0] p);
        int t;
        int guard;
        t = active;
        guard = 0;
        while (t >= 0 && guard <= NTOK) begin
            if (t >= used) begin
                t = -1;
                break;
            end
            if (is_cont(t) && tok_len[t][20]) break;
            t = $signed(tok_par[t]);
            guard++;
        end
        if (t < 0 || guard > NTOK) begin
            raise_error(ST_NO_OPEN);
        end else if (tok_kind[t] != want) begin
            raise_error(ST_MISMATCH);
        end else begin
            tok_len[t] = {1'b0, p + 20'd1 - tok_start[t]};
            active = $signed(tok_par[t]);
            add_entry(RK_FINISHED, t);
        end
    endtask

    task automatic between_tokens(logic [7:0] b, logic [19:0] p);
        int t;
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) return;
        if (b == CH_NUL) begin
            finish_doc();
        end else if (b == CH_LBRACE || b == CH_LBRACK) begin
            open_token(b == CH_LBRACE ? TK_OBJECT : TK_ARRAY, p, 21'h100000, t);
            if (t >= 0) active = t;
        end else if (b == CH_RBRACE || b == CH_RBRACK) begin
            close_cont(b == CH_RBRACE ? TK_OBJECT : TK_ARRAY, p);
        end else if (b == CH_QUOTE) begin
            open_token(TK_STRING, p + 20'd1, 21'd0, t);
            if (t >= 0) mode = M_STRING;
        end else if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS) begin
            open_token(TK_NUMBER, p, 21'd0, t);
            if (t >= 0) mode = M_NUMBER;
        end else if (b == CH_LOW_T || b == CH_LOW_F) begin
            mode     = M_LITERAL;
            lit_pos  = 1;
            lit_true = (b == CH_LOW_T);
        end else if (b == CH_COLON) begin
            active = used - 1;
        end else if (b == CH_COMMA) begin
            if (active >= 0 && active < used && !is_cont(active))
                active = $signed(tok_par[active]);
        end else begin
            raise_error(ST_BAD_BYTE);
        end
    endtask

    task automatic literal_byte(logic [7:0] b, logic [19:0] p);
        string pat;
        int    n;
        int    t;
        pat = lit_true ? "true" : "false";
        n   = pat.len();
        if (lit_pos >= n || b != pat[lit_pos]) begin
            raise_error(ST_BAD_LIT);
            if (b == CH_NUL) finish_doc();
            return;
        end
        lit_pos++;
        if (lit_pos < n) return;
        mode    = M_IDLE;
        lit_pos = 0;
        open_token(TK_BOOL, p - 20'(n - 1), 21'(n), t);
        if (t >= 0) add_entry(RK_FINISHED, t);
    endtask

    // Ends the token that is still being lexed at the last table entry.
    task automatic end_text(logic [19:0] p);
        if (used > 0) begin
            tok_len[used-1] = {1'b0, p - tok_start[used-1]};
            add_entry(RK_FINISHED, used - 1);
        end
        mode = M_IDLE;
    endtask

    task automatic predict_byte(logic [7:0] b);
        logic [19:0] p;
        p = pos;
        pos = pos + 20'd1;
        byte_words.delete();
        case (mode)
            M_STRING: begin
                if (b == CH_QUOTE) begin
                    end_text(p);
                end else if (b == CH_NUL) begin
                    raise_error(ST_BAD_BYTE);
                    finish_doc();
                end
            end
            M_NUMBER: begin
                if (!((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT)) begin
                    end_text(p);
                    between_tokens(b, p);
                end
            end
            M_LITERAL: literal_byte(b, p);
            M_DISCARD: if (b == CH_NUL) finish_doc();
            default:   between_tokens(b, p);
        endcase
        if (byte_words.size() > 0) byte_words[byte_words.size()-1].last = 1'b1;
        foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
    endtask

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            clear_state();
            expected_words.delete();
            mismatches = 0;
        end else begin
            if (i_doc_valid && i_doc_ready) predict_byte(i_doc_byte);
            if (i_res_valid && i_res_ready) begin
                got = '{i_kind, i_token_index, i_token_kind, i_start_offset,
                        i_text_length, i_parent_index, i_child_count, i_status, i_last};
                if (expected_words.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result word %h", got);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (got != want) begin
                        if (mismatches < 10)
                            $display("mismatch: expected kind=%0d idx=%0d tk=%0d st=%0d len=%0d par=%0d kids=%0d status=%0d last=%0d, got kind=%0d idx=%0d tk=%0d st=%0d len=%0d par=%0d kids=%0d status=%0d last=%0d",
                                want.kind, want.idx, want.tkind, want.start, want.len,
                                $signed(want.parent), want.kids, want.status, want.last,
                                got.kind, got.idx, got.tkind, got.start, got.len,
                                $signed(got.parent), got.kids, got.status, got.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    final begin
    end
endmodule

// File: tb/tb_json_token_table_builder.sv
`timescale 1ns / 1ps
// Top of the JSON token table builder testbench: clock, reset, document
// stimulus and verdict. Depends on jttb_pkg, the block and the result checker.
module tb_json_token_table_builder;
    import jttb_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_doc_valid;
    logic              o_doc_ready;
    logic [7:0]        i_doc_byte;
    logic              o_res_valid;
    logic              i_res_ready;
    logic [1:0]        o_kind;
    logic [10:0]       o_token_index;
    logic [2:0]        o_token_kind;
    logic [19:0]       o_start_offset;
    logic [19:0]       o_text_length;
    logic signed [10:0] o_parent_index;
    logic [10:0]       o_child_count;
    logic [2:0]        o_status;
    logic              o_last;
    int                fail_count;
    int                pending;

    logic [7:0]        doc_bytes[$];
    int                bytes_sent;
    bit                no_gaps;

    json_token_table_builder uut (.*);

    json_token_table_checker checker_i (
        .i_clk, .i_rst_n, .i_doc_valid, .i_doc_ready(o_doc_ready), .i_doc_byte,
        .i_res_valid(o_res_valid), .i_res_ready, .i_kind(o_kind),
        .i_token_index(o_token_index), .i_token_kind(o_token_kind),
        .i_start_offset(o_start_offset), .i_text_length(o_text_length),
        .i_parent_index(o_parent_index), .i_child_count(o_child_count),
        .i_status(o_status), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver stalls of random length, with ready stretches of random length between.
    initial begin
        int hold;
        i_res_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = gap_len();
            if (hold > 0) begin
                i_res_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // Ready is looked at mid-cycle, so the next rising edge is the accepting one.
    task automatic send_doc();
        int gap;
        while (doc_bytes.size() > 0) begin
            gap = no_gaps ? 0 : gap_len();
            if (gap > 0) begin
                i_doc_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_doc_valid <= 1'b1;
            i_doc_byte  <= doc_bytes.pop_front();
            @(negedge i_clk);
            while (!o_doc_ready) @(negedge i_clk);
            @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
    endtask

    task automatic put_ws();
        case ($urandom_range(0, 7))
            0: doc_bytes.push_back(CH_SPACE);
            1: doc_bytes.push_back(CH_TAB);
            2: doc_bytes.push_back(CH_CR);
            3: doc_bytes.push_back(CH_LF);
            default: ;
        endcase
    endtask

    task automatic put_string_tok();
        logic [7:0] c;
        doc_bytes.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(1, 255));
            if (c == CH_QUOTE) c = 8'hFF;
            doc_bytes.push_back(c);
        end
        doc_bytes.push_back(CH_QUOTE);
    endtask

    task automatic put_value(int depth);
        int n;
        int pick;
        pick = $urandom_range(0, depth > 3 ? 3 : 5);
        case (pick)
            0: put_string_tok();
            1: begin
                if ($urandom_range(0, 1)) doc_bytes.push_back(CH_MINUS);
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 5) == 0) doc_bytes.push_back(CH_DOT);
                    else doc_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
            end
            2: put_str("true");
            3: put_str("false");
            4: begin
                n = $urandom_range(0, 3);
                doc_bytes.push_back(CH_LBRACE);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) doc_bytes.push_back(CH_COMMA);
                    put_ws();
                    put_string_tok();
                    put_ws();
                    doc_bytes.push_back(CH_COLON);
                    put_ws();
                    put_value(depth + 1);
                    put_ws();
                end
                doc_bytes.push_back(CH_RBRACE);
            end
            default: begin
                n = $urandom_range(0, 4);
                doc_bytes.push_back(CH_LBRACK);
                for (int i = 0; i < n; i++) begin
                    if (i > 0) doc_bytes.push_back(CH_COMMA);
                    put_ws();
                    put_value(depth + 1);
                    put_ws();
                end
                doc_bytes.push_back(CH_RBRACK);
            end
        endcase
    endtask

    task automatic run_directed(string s);
        put_str(s);
        doc_bytes.push_back(CH_NUL);
        send_doc();
    endtask

    initial begin
        int kind_sel;
        int k;
        i_rst_n     <= 1'b0;
        i_doc_valid <= 1'b0;
        i_doc_byte  <= 8'h00;
        bytes_sent  = 0;
        no_gaps     = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed("{}");
        run_directed(" [ ] ");
        run_directed("{\"a\":true,\"b\":[false,-12.5,\"\"]}");
        run_directed("}");
        run_directed("[}");
        run_directed("tru!");
        run_directed("tr");
        run_directed("\"ab");
        run_directed("[1");
        run_directed(",:@");
        run_directed(":");
        run_directed("truee");
        doc_bytes.push_back(CH_QUOTE);
        doc_bytes.push_back(8'hFF);
        doc_bytes.push_back(8'h7F);
        doc_bytes.push_back(CH_QUOTE);
        doc_bytes.push_back(CH_NUL);
        send_doc();
        // One more open bracket than the table holds.
        no_gaps = 1;
        repeat (1025) doc_bytes.push_back(CH_LBRACK);
        doc_bytes.push_back(CH_RBRACK);
        doc_bytes.push_back(CH_NUL);
        send_doc();

        while (bytes_sent < 1950) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            kind_sel = $urandom_range(0, 9);
            if (kind_sel < 7) begin
                put_ws();
                put_value(0);
                put_ws();
            end else if (kind_sel < 9) begin
                put_value(0);
                // Broken document: one byte replaced or the tail cut off.
                k = $urandom_range(0, doc_bytes.size() - 1);
                if ($urandom_range(0, 1)) doc_bytes[k] = 8'($urandom_range(1, 255));
                else while (doc_bytes.size() > k + 1) void'(doc_bytes.pop_back());
            end else begin
                repeat ($urandom_range(1, 12))
                    doc_bytes.push_back(8'($urandom_range(1, 255)));
            end
            doc_bytes.push_back(CH_NUL);
            send_doc();
        end
        i_doc_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("json_token_table_builder test passed");
        end else begin
            $display("json_token_table_builder test failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("json_token_table_builder test failed");
        $finish;
    end
endmodule
